/* rtl/coin_change_min_coins_top_defines.svh */
// ----------------------------------------------------------------------------
// coin_change_min_coins_top_defines.svh
// Assertion macros used by the checker file of the coin change engine.
// ----------------------------------------------------------------------------
`ifndef COIN_CHANGE_MIN_COINS_TOP_DEFINES_SVH
`define COIN_CHANGE_MIN_COINS_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CCMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ccmc_pkg.sv */
// ----------------------------------------------------------------------------
// ccmc_pkg
// Widths, codes and interface types of the minimum-coin change engine.
// ----------------------------------------------------------------------------
package ccmc_pkg;

    localparam int VAL_W   = 8;   // denomination / amount
    localparam int COL_W   = 6;   // table column (amount) index
    localparam int TAB_W   = 7;   // table entry, holds amount+1
    localparam int TOT_W   = 6;   // coin_total field
    localparam int STAT_W  = 2;   // status field
    localparam int ODATA_W = 16;  // status + coin_total + coin_value

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_RUN    = 1'b1;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_COIN    = 1'b1;

    localparam logic [STAT_W-1:0] ST_POSSIBLE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_IMPOSSIBLE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE      = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] coin;
        logic [COL_W-1:0] col;
        logic [TAB_W-1:0] prev;
        logic [TAB_W-1:0] take;
        logic             use_take;
    } step_in_t;

    typedef struct packed {
        logic             fits;     // coin nonzero and coin <= col
        logic [COL_W-1:0] rest;     // col - coin
        logic [TAB_W-1:0] best;     // min(prev, take + 1) when use_take
        logic             differs;  // take != prev
    } step_out_t;

endpackage

/* rtl/coin_change_min_coins_top.sv */
// ----------------------------------------------------------------------------
// coin_change_min_coins_top
// Minimum-coin change engine, unbounded coin supply, table fill and backtrack.
// ----------------------------------------------------------------------------
//  channel   dir  tvalid/tready  tdata                          tuser       tlast
//  s_        in   request        value[7:0]                     operation   -
//  m_        out  result         status,coin_total,coin_value   kind        last
//
//  Append: the engine stays ready. Run of n coins, amount A: table fill row by
//  row (one cell per cycle through the table's two read ports), then backtrack
//  steps of a read and an evaluate state each (at most n+A steps), then a read and an output state per coin.
//  Not ready from a run request until its last result is loaded.
//  A stalled output holds its result; no reset sweep is needed.
// ----------------------------------------------------------------------------
module coin_change_min_coins_top #(
    parameter int MAX_COINS  = 16,
    parameter int MAX_AMOUNT = 63
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ccmc_pkg::VAL_W-1:0]   s_tdata,   // value[7:0]
    input  logic                         s_tuser,   // operation
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ccmc_pkg::ODATA_W-1:0] m_tdata,   // status[1:0], coin_total[7:2],
                                                    // coin_value[15:8]
    output logic                         m_tuser,   // kind
    output logic                         m_tlast    // last
);
    import ccmc_pkg::*;

    localparam int RW = $clog2(MAX_COINS + 1);
    localparam int DW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int SW = $clog2(MAX_AMOUNT + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ROWLD    = 4'd1;
    localparam logic [3:0] S_FILL     = 4'd2;
    localparam logic [3:0] S_DRAIN    = 4'd3;
    localparam logic [3:0] S_FIN_RD   = 4'd4;
    localparam logic [3:0] S_FIN_EV   = 4'd5;
    localparam logic [3:0] S_BT_RD    = 4'd6;
    localparam logic [3:0] S_BT_EV    = 4'd7;
    localparam logic [3:0] S_OUT_SUM  = 4'd8;
    localparam logic [3:0] S_COIN_RD  = 4'd9;
    localparam logic [3:0] S_COIN_OUT = 4'd10;

    // control
    logic [3:0]        state_reg, state_next;
    logic [RW-1:0]     count_reg, count_next;
    logic              mv_reg, mv_next;
    logic              cv_reg, cv_next;
    logic              cuse_reg, cuse_next;
    logic              cfwd_reg, cfwd_next;

    // payload
    logic [RW-1:0]     n_reg, n_next;
    logic [RW-1:0]     i_reg, i_next;
    logic [COL_W-1:0]  j_reg, j_next;
    logic [COL_W-1:0]  amt_reg, amt_next;
    logic [COL_W-1:0]  np_reg, np_next;
    logic [COL_W-1:0]  k_reg, k_next;
    logic [COL_W-1:0]  cj_reg, cj_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [TAB_W-1:0]  total_reg, total_next;
    logic [TAB_W-1:0]  best_prev_reg;
    logic              okind_reg, okind_next;
    logic [STAT_W-1:0] ostat_reg, ostat_next;
    logic [TOT_W-1:0]  ototal_reg, ototal_next;
    logic [VAL_W-1:0]  ocoin_reg, ocoin_next;
    logic              olast_reg, olast_next;

    // memories
    logic [VAL_W-1:0]  den_mem [MAX_COINS];
    logic [VAL_W-1:0]  stk_mem [MAX_AMOUNT + 1];
    logic [VAL_W-1:0]  den_rd_reg, stk_rd_reg;
    logic              den_we, stk_we;
    logic [RW-1:0]     den_ra;
    logic [COL_W-1:0]  stk_ra;

    logic              s_acc, out_free;
    logic [TAB_W-1:0]  inf, rd_a, rd_b;
    logic [RW-1:0]     rd_row_a;
    logic [COL_W-1:0]  rd_col_b;
    step_in_t          step_req;
    step_out_t         step_rsp;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign inf      = {1'b0, amt_reg} + TAB_W'(1);
    assign den_ra   = i_reg - RW'(1);
    assign stk_ra   = np_reg - k_reg - COL_W'(1);
    assign rd_row_a = (state_reg == S_FIN_RD) ? i_reg : (i_reg - RW'(1));
    assign rd_col_b = (state_reg == S_FILL) ? step_rsp.rest : j_reg;

    always_comb
    begin
        step_req.coin     = den_rd_reg;
        step_req.col      = j_reg;
        step_req.prev     = rd_a;
        step_req.take     = cfwd_reg ? best_prev_reg : rd_b;
        step_req.use_take = cuse_reg;
    end

    ccmc_step_unit u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    ccmc_table #(
        .MAX_COINS (MAX_COINS)
    ) u_table (
        .clk      (clk),
        .wr_en    (cv_reg),
        .wr_row   (i_reg),
        .wr_col   (cj_reg),
        .wr_data  (step_rsp.best),
        .rd_row_a (rd_row_a),
        .rd_col_a (j_reg),
        .rd_row_b (i_reg),
        .rd_col_b (rd_col_b),
        .inf      (inf),
        .rd_a     (rd_a),
        .rd_b     (rd_b)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        mv_next     = mv_reg && !m_tready;
        cv_next     = 1'b0;
        cuse_next   = 1'b0;
        cfwd_next   = 1'b0;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        amt_next    = amt_reg;
        np_next     = np_reg;
        k_next      = k_reg;
        cj_next     = j_reg;
        status_next = status_reg;
        total_next  = total_reg;
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        ototal_next = ototal_reg;
        ocoin_next  = ocoin_reg;
        olast_next  = olast_reg;
        den_we      = 1'b0;
        stk_we      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if (s_tuser == OP_APPEND)
                    begin
                        if (count_reg < RW'(MAX_COINS))
                        begin
                            den_we     = 1'b1;
                            count_next = count_reg + RW'(1);
                        end
                    end
                    else
                    begin
                        count_next = '0;
                        np_next    = '0;
                        if (s_tdata > VAL_W'(MAX_AMOUNT))
                        begin
                            status_next = ST_RANGE;
                            total_next  = '0;
                            state_next  = S_OUT_SUM;
                        end
                        else
                        begin
                            n_next   = count_reg;
                            amt_next = s_tdata[COL_W-1:0];
                            if ((count_reg != '0) && (s_tdata != '0))
                            begin
                                i_next     = RW'(1);
                                j_next     = COL_W'(1);
                                state_next = S_ROWLD;
                            end
                            else
                            begin
                                // empty list or zero amount: table is all virtual
                                i_next     = count_reg;
                                j_next     = s_tdata[COL_W-1:0];
                                state_next = S_FIN_RD;
                            end
                        end
                    end
                end
            end

            S_ROWLD:
            begin
                state_next = S_FILL;
            end

            S_FILL:
            begin
                cv_next   = 1'b1;
                cuse_next = step_rsp.fits;
                // unit coin reads the cell still being written: forward it
                cfwd_next = (den_rd_reg == VAL_W'(1)) && (j_reg > COL_W'(1));
                if (j_reg == amt_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + COL_W'(1);
                end
            end

            S_DRAIN:
            begin
                if (i_reg == n_reg)
                begin
                    j_next     = amt_reg;
                    state_next = S_FIN_RD;
                end
                else
                begin
                    i_next     = i_reg + RW'(1);
                    j_next     = COL_W'(1);
                    state_next = S_ROWLD;
                end
            end

            S_FIN_RD:
            begin
                state_next = S_FIN_EV;
            end

            S_FIN_EV:
            begin
                if (rd_a > {1'b0, amt_reg})
                begin
                    status_next = ST_IMPOSSIBLE;
                    total_next  = '0;
                    state_next  = S_OUT_SUM;
                end
                else
                begin
                    status_next = ST_POSSIBLE;
                    total_next  = rd_a;
                    state_next  = S_BT_RD;
                end
            end

            S_BT_RD:
            begin
                if ((i_reg == '0) || (j_reg == '0))
                begin
                    state_next = S_OUT_SUM;
                end
                else
                begin
                    state_next = S_BT_EV;
                end
            end

            S_BT_EV:
            begin
                // rd_a is the row above, rd_b this row
                if (step_rsp.differs && step_rsp.fits)
                begin
                    stk_we  = 1'b1;
                    np_next = np_reg + COL_W'(1);
                    j_next  = step_rsp.rest;
                end
                else
                begin
                    i_next = i_reg - RW'(1);
                end
                state_next = S_BT_RD;
            end

            S_OUT_SUM:
            begin
                if (out_free)
                begin
                    mv_next     = 1'b1;
                    okind_next  = KIND_SUMMARY;
                    ostat_next  = status_reg;
                    ototal_next = TOT_W'(total_reg);
                    ocoin_next  = '0;
                    olast_next  = (np_reg == '0);
                    k_next      = '0;
                    state_next  = (np_reg == '0) ? S_IDLE : S_COIN_RD;
                end
            end

            S_COIN_RD:
            begin
                state_next = S_COIN_OUT;
            end

            S_COIN_OUT:
            begin
                if (out_free)
                begin
                    mv_next     = 1'b1;
                    okind_next  = KIND_COIN;
                    ostat_next  = ST_POSSIBLE;
                    ototal_next = '0;
                    ocoin_next  = stk_rd_reg;
                    olast_next  = ((k_reg + COL_W'(1)) == np_reg);
                    k_next      = k_reg + COL_W'(1);
                    state_next  = ((k_reg + COL_W'(1)) == np_reg) ? S_IDLE : S_COIN_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
            cv_reg    <= 1'b0;
            cuse_reg  <= 1'b0;
            cfwd_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
            cv_reg    <= cv_next;
            cuse_reg  <= cuse_next;
            cfwd_reg  <= cfwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        amt_reg    <= amt_next;
        np_reg     <= np_next;
        k_reg      <= k_next;
        cj_reg     <= cj_next;
        status_reg <= status_next;
        total_reg  <= total_next;
        okind_reg  <= okind_next;
        ostat_reg  <= ostat_next;
        ototal_reg <= ototal_next;
        ocoin_reg  <= ocoin_next;
        olast_reg  <= olast_next;
        if (cv_reg)
        begin
            best_prev_reg <= step_rsp.best;
        end
    end

    always_ff @(posedge clk)
    begin
        if (den_we)
        begin
            den_mem[count_reg[DW-1:0]] <= s_tdata;
        end
        den_rd_reg <= den_mem[den_ra[DW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[SW'(np_reg)] <= den_rd_reg;
        end
        stk_rd_reg <= stk_mem[SW'(stk_ra)];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {ocoin_reg, ototal_reg, ostat_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

endmodule

/* rtl/ccmc_step_unit.sv */
// ----------------------------------------------------------------------------
// ccmc_step_unit
// Shared subtract/compare/min unit used by both table fill and backtrack.
// ----------------------------------------------------------------------------
module ccmc_step_unit (
    input  ccmc_pkg::step_in_t  req,
    output ccmc_pkg::step_out_t rsp
);
    import ccmc_pkg::*;

    logic [VAL_W:0]   diff;
    logic [TAB_W-1:0] take1;

    always_comb
    begin
        diff  = {1'b0, VAL_W'(req.col)} - {1'b0, req.coin};
        take1 = req.take + TAB_W'(1);
        rsp.fits    = (req.coin != '0) && !diff[VAL_W];
        rsp.rest    = diff[COL_W-1:0];
        rsp.best    = (req.use_take && (take1 < req.prev)) ? take1 : req.prev;
        rsp.differs = (req.take != req.prev);
    end

endmodule

/* rtl/ccmc_table.sv */
// ----------------------------------------------------------------------------
// ccmc_table
// Minimum-coin table: one write port, two registered read ports. Row 0 and
// column 0 are not stored; they read as amount+1 and zero.
// ----------------------------------------------------------------------------
module ccmc_table #(
    parameter int MAX_COINS = 16,
    localparam int RW = $clog2(MAX_COINS + 1)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [RW-1:0]              wr_row,
    input  logic [ccmc_pkg::COL_W-1:0] wr_col,
    input  logic [ccmc_pkg::TAB_W-1:0] wr_data,
    input  logic [RW-1:0]              rd_row_a,
    input  logic [ccmc_pkg::COL_W-1:0] rd_col_a,
    input  logic [RW-1:0]              rd_row_b,
    input  logic [ccmc_pkg::COL_W-1:0] rd_col_b,
    input  logic [ccmc_pkg::TAB_W-1:0] inf,
    output logic [ccmc_pkg::TAB_W-1:0] rd_a,
    output logic [ccmc_pkg::TAB_W-1:0] rd_b
);
    import ccmc_pkg::*;

    localparam int DW    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int AW    = DW + COL_W;
    localparam int DEPTH = 1 << AW;

    logic [TAB_W-1:0] mem [DEPTH];
    logic [TAB_W-1:0] qa_reg, qb_reg;
    logic             za_reg, zb_reg;   // column zero
    logic             ia_reg, ib_reg;   // row zero
    logic [RW-1:0]    wr_m1, ra_m1, rb_m1;

    assign wr_m1 = wr_row - RW'(1);
    assign ra_m1 = rd_row_a - RW'(1);
    assign rb_m1 = rd_row_b - RW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_m1[DW-1:0], wr_col}] <= wr_data;
        end
        qa_reg <= mem[{ra_m1[DW-1:0], rd_col_a}];
        qb_reg <= mem[{rb_m1[DW-1:0], rd_col_b}];
        za_reg <= (rd_col_a == '0);
        zb_reg <= (rd_col_b == '0);
        ia_reg <= (rd_row_a == '0);
        ib_reg <= (rd_row_b == '0);
    end

    assign rd_a = za_reg ? '0 : (ia_reg ? inf : qa_reg);
    assign rd_b = zb_reg ? '0 : (ib_reg ? inf : qb_reg);

endmodule

/* rtl/ccmc_checker.sv */
// ----------------------------------------------------------------------------
// ccmc_checker
// Port-level checks of the coin change engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "coin_change_min_coins_top_defines.svh"

module ccmc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [ccmc_pkg::VAL_W-1:0]   s_tdata,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ccmc_pkg::ODATA_W-1:0] m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);
    import ccmc_pkg::*;

    // a stalled result stays offered
    `CCMC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a run request starts work, so the request side closes
    `CCMC_ASSERT_NEXT(a_run_busy, s_tvalid && s_tready && (s_tuser == OP_RUN), !s_tready, "still ready after a run request")

    // an append finishes at once
    `CCMC_ASSERT_NEXT(a_append_idle, s_tvalid && s_tready && (s_tuser == OP_APPEND), s_tready, "not ready after an append")

    // coin results carry no status and no total
    `CCMC_ASSERT_NOW(a_coin_clean, m_tvalid && (m_tuser == KIND_COIN), m_tdata[7:0] == 8'd0, "coin result with status or total")

    // a failed run ends on its summary
    `CCMC_ASSERT_NOW(a_fail_last, m_tvalid && (m_tuser == KIND_SUMMARY) && (m_tdata[1:0] != ST_POSSIBLE), m_tlast, "failed summary not last")

endmodule

bind coin_change_min_coins_top ccmc_checker u_ccmc_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum-coin change engine. Loads denominations,
// issues run requests and compares every summary and coin result with a local
// table-fill and backtrack predictor, under random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import ccmc_pkg::*;

    localparam int MAX_COINS   = 16;
    localparam int MAX_AMOUNT  = 63;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic              kind;
        logic [STAT_W-1:0] status;
        logic [TOT_W-1:0]  total;
        logic [VAL_W-1:0]  coin;
        logic              last;
    } coin_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VAL_W-1:0]   s_tdata = '0;      // value[7:0]
    logic               s_tuser = OP_APPEND; // operation
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [ODATA_W-1:0] m_tdata;           // status[1:0], coin_total[7:2], coin_value[15:8]
    logic               m_tuser;           // kind
    logic               m_tlast;           // last

    coin_answer_t coin_answers_q[$];
    logic [VAL_W-1:0] coin_list [MAX_COINS];
    int coins_held = 0;
    int error_count = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    logic hold_on = 1'b0;
    event hold_kick;

    coin_change_min_coins_top #(
        .MAX_COINS  (MAX_COINS),
        .MAX_AMOUNT (MAX_AMOUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor: unbounded-supply min-coin table, then backtrack
    // ------------------------------------------------------------------
    task automatic push_answer(logic kind, logic [STAT_W-1:0] status, int total,
                               int coin, logic last);
        coin_answer_t a;
        a.kind   = kind;
        a.status = status;
        a.total  = total[TOT_W-1:0];
        a.coin   = coin[VAL_W-1:0];
        a.last   = last;
        coin_answers_q.insert(coin_answers_q.size(), a);
    endtask

    task automatic predict_change(logic op, logic [VAL_W-1:0] val);
        int tbl [0:MAX_COINS][0:MAX_AMOUNT];
        int picks [$];
        int n;
        int amount;
        int i;
        int j;
        int c;
        int best;
        if (op == OP_APPEND) begin
            if (coins_held < MAX_COINS) begin
                coin_list[coins_held] = val;
                coins_held++;
            end
            return;
        end
        n = coins_held;
        amount = val;
        coins_held = 0;
        if (amount > MAX_AMOUNT) begin
            push_answer(KIND_SUMMARY, ST_RANGE, 0, 0, 1'b1);
            return;
        end
        for (i = 0; i <= n; i++)
            tbl[i][0] = 0;
        for (j = 1; j <= amount; j++)
            tbl[0][j] = amount + 1;   // unreachable marker
        for (i = 1; i <= n; i++) begin
            c = coin_list[i-1];
            for (j = 1; j <= amount; j++) begin
                best = tbl[i-1][j];
                if (c != 0 && j >= c && tbl[i][j-c] + 1 < best)
                    best = tbl[i][j-c] + 1;
                tbl[i][j] = best;
            end
        end
        if (tbl[n][amount] > amount) begin
            push_answer(KIND_SUMMARY, ST_IMPOSSIBLE, 0, 0, 1'b1);
            return;
        end
        i = n;
        j = amount;
        while (i > 0 && j > 0 && picks.size() <= MAX_AMOUNT) begin
            c = coin_list[i-1];
            if (tbl[i][j] != tbl[i-1][j] && c != 0 && c <= j) begin
                picks.insert(picks.size(), c);
                j -= c;
            end
            else
                i--;
        end
        push_answer(KIND_SUMMARY, ST_POSSIBLE, tbl[n][amount], 0, picks.size() == 0);
        for (int k = 0; k < picks.size(); k++)
            push_answer(KIND_COIN, ST_POSSIBLE, 0, picks[picks.size()-1-k],
                        k + 1 == picks.size());
    endtask

    // ------------------------------------------------------------------
    // result side: random ready, long hold-off on request, checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic check_answer();
        coin_answer_t exp_a;
        if (coin_answers_q.size() == 0) begin
            report_mismatch("unexpected result, kind", m_tuser, -1);
            return;
        end
        exp_a = coin_answers_q.pop_front();
        if (m_tuser !== exp_a.kind)
            report_mismatch("kind", m_tuser, exp_a.kind);
        if (m_tdata[1:0] !== exp_a.status)
            report_mismatch("status", m_tdata[1:0], exp_a.status);
        if (m_tdata[7:2] !== exp_a.total)
            report_mismatch("coin_total", m_tdata[7:2], exp_a.total);
        if (m_tdata[15:8] !== exp_a.coin)
            report_mismatch("coin_value", m_tdata[15:8], exp_a.coin);
        if (m_tlast !== exp_a.last)
            report_mismatch("last", m_tlast, exp_a.last);
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            check_answer();
        m_tready <= !hold_on && ($urandom_range(99) >= snk_idle_pct);
    end

    // hold-off stretch, started by the stall test
    initial begin
        forever begin
            @(hold_kick);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_request(logic op, logic [VAL_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_change(op, val);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (coin_answers_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_list();
        send_request(OP_RUN, 8'd0);     // zero amount, nothing to pick
        send_request(OP_RUN, 8'd5);     // no coins at all
        wait_results_done();
    endtask

    task automatic test_out_of_range();
        send_request(OP_APPEND, 8'd255);
        send_request(OP_RUN, 8'd255);
        send_request(OP_APPEND, 8'd3);
        send_request(OP_RUN, 8'd64);    // first amount past the limit, clears list
        send_request(OP_RUN, 8'd3);     // list is empty again
        wait_results_done();
    endtask

    task automatic test_zero_denomination();
        send_request(OP_APPEND, 8'd0);
        send_request(OP_APPEND, 8'd3);
        send_request(OP_APPEND, 8'd0);
        send_request(OP_RUN, 8'd6);
        send_request(OP_APPEND, 8'd0);
        send_request(OP_RUN, 8'd1);
        wait_results_done();
    endtask

    task automatic test_impossible();
        send_request(OP_APPEND, 8'd2);
        send_request(OP_APPEND, 8'd4);
        send_request(OP_RUN, 8'd7);
        wait_results_done();
    endtask

    task automatic test_longest_answer();
        send_request(OP_APPEND, 8'd1);
        send_request(OP_RUN, 8'd63);    // 63 coins of one
        send_request(OP_APPEND, 8'd1);
        send_request(OP_APPEND, 8'd3);
        send_request(OP_APPEND, 8'd4);
        send_request(OP_RUN, 8'd6);     // greedy would take three
        wait_results_done();
    endtask

    task automatic test_list_full();
        for (int k = 0; k < MAX_COINS; k++)
            send_request(OP_APPEND, 8'd5);
        send_request(OP_APPEND, 8'd1);  // dropped
        send_request(OP_RUN, 8'd63);
        for (int k = 0; k < MAX_COINS; k++)
            send_request(OP_APPEND, VAL_W'($urandom_range(1, 63)));
        send_request(OP_RUN, 8'd63);
        wait_results_done();
    endtask

    // receiver holds off while requests keep coming, so the engine backs up
    task automatic test_stall_backpressure();
        -> hold_kick;
        for (int r = 0; r < 3; r++) begin
            send_request(OP_APPEND, 8'd1);
            send_request(OP_APPEND, VAL_W'($urandom_range(2, 9)));
            send_request(OP_RUN, VAL_W'($urandom_range(10, 40)));
        end
        wait_results_done();
    endtask

    task automatic test_random_traffic(int n_items, int src_pct, int snk_pct);
        int sent;
        int amount;
        int ncoins;
        int coin;
        sent = 0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        while (sent < n_items) begin
            if (($urandom_range(9) < 7) && (n_items - sent >= 2)) begin
                amount = ($urandom_range(3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 20);
                ncoins = ($urandom_range(7) == 0) ? $urandom_range(5, 18)
                                                   : $urandom_range(1, 4);
                if (ncoins > n_items - sent - 1)
                    ncoins = n_items - sent - 1;
                for (int k = 0; k < ncoins; k++) begin
                    case ($urandom_range(9))
                        0:       coin = 0;
                        1:       coin = $urandom_range(0, 255);
                        default: coin = $urandom_range(1, (amount > 1) ? amount : 2);
                    endcase
                    send_request(OP_APPEND, VAL_W'(coin));
                    sent++;
                end
                send_request(OP_RUN, VAL_W'(amount));
                sent++;
            end
            else begin
                // noise: lone request, any op, any value
                if ($urandom_range(1) == 0)
                    send_request(OP_APPEND, VAL_W'($urandom_range(0, 255)));
                else
                    send_request(OP_RUN, VAL_W'($urandom_range(0, 255)));
                sent++;
            end
        end
        wait_results_done();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 36;
        snk_idle_pct = 50;
        test_empty_list();
        test_out_of_range();
        test_zero_denomination();
        test_impossible();
        test_longest_answer();
        test_list_full();
        test_stall_backpressure();

        test_random_traffic(22, 36, 50);
        test_random_traffic(22, 50, 36);
        test_random_traffic(20, 0, 0);

        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
